// ----- rtl/core/xcfd_pkg.sv -----
package xcfd_pkg;

   localparam int MAX_PAYLOAD = 64;
   localparam int IDX_W       = $clog2(MAX_PAYLOAD);
   localparam int LEN_W       = IDX_W + 1;
   localparam int FUNC_W      = 16;
   localparam int BYTE_W      = 8;
   localparam int MEM_AW      = IDX_W + 1;   // bank bit on top of the byte index
   localparam int MEM_DEPTH   = 2 * MAX_PAYLOAD;

   localparam logic CSR_START_BYTE   = 1'b0;
   localparam logic CSR_LENGTH_LIMIT = 1'b1;

   typedef struct packed {
      logic [BYTE_W-1:0] start_byte;
      logic [LEN_W-1:0]  length_limit;
   } cfg_type;

   typedef struct packed {
      logic              en;
      logic [MEM_AW-1:0] addr;
      logic [BYTE_W-1:0] data;
   } wr_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [LEN_W-1:0]  len;
      logic              bank;
   } desc_type;

endpackage

// ----- rtl/core/xcfd_if.sv -----
interface xcfd_req_if import xcfd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface xcfd_rsp_if import xcfd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] function_code;
   logic [LEN_W-1:0]  payload_length;
   logic              has_payload;
   logic [IDX_W-1:0]  byte_index;
   logic [BYTE_W-1:0] payload_byte;
   logic              last;

   modport source (output valid, output function_code, output payload_length,
                   output has_payload, output byte_index, output payload_byte,
                   output last, input ready);
   modport sink   (input valid, input function_code, input payload_length,
                   input has_payload, input byte_index, input payload_byte,
                   input last, output ready);
endinterface

// ----- rtl/core/xcfd_front.sv -----
module xcfd_front import xcfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   xcfd_req_if.sink   req,
   input  cfg_type    cfg,
   input  logic       q_full,
   output wr_type     wr,
   output logic       push,
   output desc_type   desc
);

   typedef enum logic [2:0] {
      PH_WAIT, PH_FMSB, PH_FLSB, PH_LMSB, PH_LLSB, PH_DATA, PH_CHK
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [FUNC_W-1:0] func_ff, func_in;
   logic [BYTE_W-1:0] len_hi_ff, len_hi_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0] check_ff, check_in;
   logic              bank_ff, bank_in;

   logic              accept;
   logic [BYTE_W-1:0] c;
   logic [LEN_W-1:0]  eff_lim;
   logic [15:0]       full_len;
   logic [LEN_W-1:0]  count_inc;

   // both buffer banks held by verified frames: hold off the sender
   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign c         = req.rx_byte;
   assign eff_lim   = (cfg.length_limit > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                              : cfg.length_limit;
   assign full_len  = {len_hi_ff, c};
   assign count_inc = count_ff + LEN_W'(1);

   always_comb begin
      phase_in  = phase_ff;
      func_in   = func_ff;
      len_hi_in = len_hi_ff;
      len_in    = len_ff;
      count_in  = count_ff;
      check_in  = check_ff;
      bank_in   = bank_ff;
      wr.en     = 1'b0;
      wr.addr   = {bank_ff, count_ff[IDX_W-1:0]};
      wr.data   = c;
      push      = 1'b0;
      desc      = '{func: func_ff, len: len_ff, bank: bank_ff};
      if (accept) begin
         unique case (phase_ff)
            PH_FMSB: begin
               func_in  = {c, 8'h00};
               check_in = check_ff ^ c;
               phase_in = PH_FLSB;
            end
            PH_FLSB: begin
               func_in  = {func_ff[FUNC_W-1:8], c};
               check_in = check_ff ^ c;
               phase_in = PH_LMSB;
            end
            PH_LMSB: begin
               len_hi_in = c;
               check_in  = check_ff ^ c;
               phase_in  = PH_LLSB;
            end
            PH_LLSB: begin
               check_in = check_ff ^ c;
               count_in = '0;
               len_in   = full_len[LEN_W-1:0];
               if (full_len > {{(16-LEN_W){1'b0}}, eff_lim}) begin
                  phase_in = PH_WAIT;
               end else if (full_len == 16'h0000) begin
                  phase_in = PH_CHK;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               wr.en    = 1'b1;
               count_in = count_inc;
               check_in = check_ff ^ c;
               if (count_inc >= len_ff) begin
                  phase_in = PH_CHK;
               end
            end
            PH_CHK: begin
               phase_in = PH_WAIT;
               if (c == check_ff) begin
                  push    = 1'b1;
                  bank_in = ~bank_ff;
               end
            end
            default: begin
               phase_in = PH_WAIT;
               if (c == cfg.start_byte) begin
                  func_in  = '0;
                  count_in = '0;
                  check_in = c;
                  phase_in = PH_FMSB;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         func_ff  <= '0;
         len_ff   <= '0;
         count_ff <= '0;
         check_ff <= '0;
         bank_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         func_ff  <= func_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         check_ff <= check_in;
         bank_ff  <= bank_in;
      end
   end

   always_ff @(posedge clock) begin
      len_hi_ff <= len_hi_in;
   end

endmodule

// ----- rtl/core/xcfd_queue.sv -----
module xcfd_queue import xcfd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   input  logic     pop,
   output desc_type head,
   output logic     head_valid,
   output logic     full
);

   desc_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = (cnt_ff != 2'd0);
   assign full       = (cnt_ff == 2'd2);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ----- rtl/core/xcfd_back.sv -----
module xcfd_back import xcfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  wr_type     wr,
   input  desc_type   head,
   input  logic       head_valid,
   output logic       pop,
   xcfd_rsp_if.source rsp
);

   typedef enum logic {B_IDLE, B_SHOW} bstate_type;

   bstate_type        state_ff, state_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic [BYTE_W-1:0] mem_ff [MEM_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;
   logic              rd_en;
   logic [MEM_AW-1:0] rd_addr;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [FUNC_W-1:0] func_ff, func_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              has_ff, has_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              last_ff, last_in;

   logic              out_free;
   logic              has_pl;
   logic              is_last;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign has_pl   = (head.len != '0);
   assign is_last  = !has_pl || (({1'b0, k_ff} + LEN_W'(1)) == head.len);

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      rd_en        = 1'b0;
      rd_addr      = {head.bank, k_ff + IDX_W'(1)};
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      func_in      = func_ff;
      len_in       = len_ff;
      has_in       = has_ff;
      idx_in       = idx_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (head_valid) begin
               k_in     = '0;
               state_in = B_SHOW;
               rd_en    = has_pl;
               rd_addr  = {head.bank, {IDX_W{1'b0}}};
            end
         end
         B_SHOW: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               func_in      = head.func;
               len_in       = head.len;
               has_in       = has_pl;
               idx_in       = has_pl ? k_ff : '0;
               byte_in      = has_pl ? rd_data_ff : '0;
               last_in      = is_last;
               if (is_last) begin
                  pop      = 1'b1;
                  state_in = B_IDLE;
               end else begin
                  k_in  = k_ff + IDX_W'(1);
                  rd_en = 1'b1;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      len_ff  <= len_in;
      has_ff  <= has_in;
      idx_ff  <= idx_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   // two banks: one filling from the front while the other drains
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.function_code  = func_ff;
   assign rsp.payload_length = len_ff;
   assign rsp.has_payload    = has_ff;
   assign rsp.byte_index     = idx_ff;
   assign rsp.payload_byte   = byte_ff;
   assign rsp.last           = last_ff;

endmodule

// ----- rtl/core/xor_checked_frame_deframer.sv -----
// Frame deframer with XOR checksum.
// req_if carries received bytes, one per transaction. A frame is the start
// byte, a 16-bit function code and a 16-bit length (high byte first), the
// payload and a checksum byte equal to the XOR of all bytes before it.
// rsp_if gives one transaction per payload byte of a verified frame, or a
// single transaction with has_payload low for an empty frame; last marks the
// final one. Bad checksums and over-limit lengths are dropped silently.
// csr_we/csr_index/csr_wdata write start_byte (index 0) and length_limit
// (index 1); write only while the block is idle.
// Input: one byte per cycle. The payload buffer has two banks, so the next
// frame is received while the previous one drains; req_if.ready drops only
// when two verified frames are still waiting to drain.
// Output: after the checksum byte come the queue, buffer read and output
// registers; then one result per cycle, set by the single buffer read port.
// A stalled receiver holds the output register and backs up into the queue.
// Reset (synchronous) returns to waiting for a start byte, empties the queue
// and restores start_byte 0xFE and length_limit 64.
module xor_checked_frame_deframer import xcfd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   xcfd_req_if.sink          req_if,
   xcfd_rsp_if.source        rsp_if,
   input  logic              csr_we,
   input  logic [0:0]        csr_index,
   input  logic [BYTE_W-1:0] csr_wdata
);

   cfg_type  cfg_ff;
   wr_type   wr;
   logic     push;
   desc_type push_desc;
   desc_type head;
   logic     head_valid;
   logic     q_full;
   logic     pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte   <= 8'hFE;
         cfg_ff.length_limit <= LEN_W'(MAX_PAYLOAD);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_BYTE:   cfg_ff.start_byte   <= csr_wdata;
            CSR_LENGTH_LIMIT: cfg_ff.length_limit <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   xcfd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_if),
      .cfg    (cfg_ff),
      .q_full (q_full),
      .wr     (wr),
      .push   (push),
      .desc   (push_desc)
   );

   xcfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (q_full)
   );

   xcfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp        (rsp_if)
   );

   // the front never fills a bank that a waiting frame still owns
   a_bank_free: assert property (@(posedge clock) disable iff (reset)
      (wr.en && head_valid) |-> (wr.addr[MEM_AW-1] != head.bank))
      else $error("payload write into a bank still queued for readout");

   a_empty_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.has_payload) |->
         (rsp_if.last && rsp_if.byte_index == '0 && rsp_if.payload_length == '0))
      else $error("empty-frame result malformed");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.has_payload) |->
         ({1'b0, rsp_if.byte_index} < rsp_if.payload_length))
      else $error("byte index beyond payload length");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (push && q_full) |-> pop)
      else $error("frame descriptor pushed into full queue");

endmodule

// ----- tb/sv/tb.sv -----
module tb;
   import xcfd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 45;
   localparam int MAX_REPORTS  = 40;

   typedef enum logic [2:0] {
      RX_IDLE, RX_FUNC_HI, RX_FUNC_LO, RX_LEN_HI, RX_LEN_LO, RX_DATA, RX_CHECK
   } rx_phase_type;

   typedef struct {
      logic [FUNC_W-1:0] func;
      logic [LEN_W-1:0]  len;
      logic              has_payload;
      logic [IDX_W-1:0]  idx;
      logic [BYTE_W-1:0] data;
      logic              last;
   } deframed_type;

   logic clock = 1'b0;
   logic reset;
   logic              csr_we;
   logic [0:0]        csr_index;
   logic [BYTE_W-1:0] csr_wdata;

   xcfd_req_if req_if ();
   xcfd_rsp_if rsp_if ();

   xor_checked_frame_deframer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the block: configuration and receive state
   logic [BYTE_W-1:0] cfg_sof   = 8'hFE;
   logic [LEN_W-1:0]  cfg_limit = 7'd64;
   rx_phase_type      rx_phase  = RX_IDLE;
   logic [15:0]       cur_func, cur_len;
   logic [LEN_W-1:0]  data_count;
   logic [BYTE_W-1:0] xor_acc;
   logic [BYTE_W-1:0] data_buf [MAX_PAYLOAD];

   deframed_type pending_results [$];

   int error_count        = 0;
   int cycle_count        = 0;
   int bytes_sent         = 0;
   int results_checked    = 0;
   int frames_verified    = 0;
   int frames_dropped     = 0;
   int input_stall_cycles = 0;

   bit req_gaps      = 1'b1;
   bit rsp_stalls_on = 1'b1;
   bit hold_off_req  = 1'b0;
   int hold_off_cycles = 0;

   // mostly short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 6);
      return $urandom_range(15, 40);
   endfunction

   function automatic int limit_now();
      return (cfg_limit > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(cfg_limit);
   endfunction

   task automatic deframe_byte(input logic [BYTE_W-1:0] b);
      int n;
      deframed_type res;
      case (rx_phase)
         RX_FUNC_HI: begin
            cur_func = {b, 8'h00};
            xor_acc ^= b;
            rx_phase = RX_FUNC_LO;
         end
         RX_FUNC_LO: begin
            cur_func[7:0] = b;
            xor_acc ^= b;
            rx_phase = RX_LEN_HI;
         end
         RX_LEN_HI: begin
            cur_len = {b, 8'h00};
            xor_acc ^= b;
            rx_phase = RX_LEN_LO;
         end
         RX_LEN_LO: begin
            cur_len[7:0] = b;
            xor_acc ^= b;
            data_count = '0;
            if (int'(cur_len) > limit_now()) begin
               rx_phase = RX_IDLE;
               frames_dropped++;
            end else if (cur_len == 0)
               rx_phase = RX_CHECK;
            else
               rx_phase = RX_DATA;
         end
         RX_DATA: begin
            if (data_count < MAX_PAYLOAD) data_buf[data_count[IDX_W-1:0]] = b;
            data_count = data_count + LEN_W'(1);
            xor_acc ^= b;
            if (data_count >= cur_len) rx_phase = RX_CHECK;
         end
         RX_CHECK: begin
            rx_phase = RX_IDLE;
            if (b == xor_acc) begin
               frames_verified++;
               n = (cur_len > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(cur_len);
               res.func = cur_func;
               if (n == 0) begin
                  res.len = '0;
                  res.has_payload = 1'b0;
                  res.idx = '0;
                  res.data = '0;
                  res.last = 1'b1;
                  pending_results.push_back(res);
               end else begin
                  for (int k = 0; k < n; k++) begin
                     res.len = LEN_W'(n);
                     res.has_payload = 1'b1;
                     res.idx = IDX_W'(k);
                     res.data = data_buf[k];
                     res.last = (k + 1 == n);
                     pending_results.push_back(res);
                  end
               end
            end else
               frames_dropped++;
         end
         default: begin
            rx_phase = RX_IDLE;
            if (b == cfg_sof) begin
               cur_func = '0;
               cur_len = '0;
               data_count = '0;
               xor_acc = b;
               rx_phase = RX_FUNC_HI;
            end
         end
      endcase
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      gap = (req_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      do begin
         @(posedge clock);
         if (!req_if.ready) input_stall_cycles++;
      end while (!req_if.ready);
      deframe_byte(b);
      bytes_sent++;
   endtask

   // fill < 0 gives random payload; an over-limit frame stops after its length
   task automatic send_frame(input logic [15:0] func, input logic [15:0] len,
                             input bit bad_sum, input int fill);
      logic [BYTE_W-1:0] frame_q [$];
      logic [BYTE_W-1:0] sum;
      frame_q = {cfg_sof, func[15:8], func[7:0], len[15:8], len[7:0]};
      if (int'(len) <= limit_now()) begin
         for (int k = 0; k < len; k++)
            frame_q.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
         sum = '0;
         foreach (frame_q[k]) sum ^= frame_q[k];
         if (bad_sum) sum ^= 8'(1 << $urandom_range(0, 7));
         frame_q.push_back(sum);
      end
      foreach (frame_q[k]) send_byte(frame_q[k]);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [BYTE_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_START_BYTE)
         cfg_sof = val;
      else
         cfg_limit = val[LEN_W-1:0];
   endtask

   // dropped frames leave nothing to wait for, so always pad with a drain time
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed();
      send_frame(16'hFFFF, 16'd0, 1'b0, -1);
      send_frame(16'h0000, 16'd1, 1'b0, 8'hFF);
      send_frame(16'h1234, 16'd0, 1'b1, -1);
      send_frame(16'hA55A, 16'h0100, 1'b0, -1);
   endtask

   task automatic test_length_limits();
      wait_idle();
      write_csr(CSR_LENGTH_LIMIT, 8'd0);
      send_frame(16'h0F0F, 16'd0, 1'b0, -1);
      send_frame(16'h0F0F, 16'd1, 1'b0, -1);
      wait_idle();
      write_csr(CSR_LENGTH_LIMIT, 8'd1);
      write_csr(CSR_START_BYTE, 8'h00);
      send_frame(16'h8001, 16'd1, 1'b0, 8'h00);
      send_frame(16'h8001, 16'd2, 1'b0, -1);
      wait_idle();
      // top bit of the write data is outside the register
      write_csr(CSR_LENGTH_LIMIT, 8'hC0);
      write_csr(CSR_START_BYTE, 8'hFF);
      send_frame(16'h7FFE, 16'd10, 1'b0, -1);
      send_frame(16'h7FFE, 16'h0141, 1'b0, -1);
      send_frame(16'h7FFE, 16'h8000, 1'b0, -1);
      wait_idle();
      // register above the buffer size still caps at the buffer size
      write_csr(CSR_LENGTH_LIMIT, 8'h7F);
      send_frame(16'h5AA5, 16'd64, 1'b0, -1);
      send_frame(16'h5AA5, 16'd65, 1'b0, -1);
   endtask

   task automatic test_random();
      int r, lim, stop_at;
      logic [15:0] len;
      for (int chunk = 0; chunk < 3; chunk++) begin
         wait_idle();
         if (chunk == 0) begin
            write_csr(CSR_START_BYTE, 8'hFE);
            write_csr(CSR_LENGTH_LIMIT, 8'd64);
         end else begin
            write_csr(CSR_START_BYTE, 8'($urandom_range(0, 255)));
            write_csr(CSR_LENGTH_LIMIT, 8'($urandom_range(3, 64)));
         end
         stop_at = bytes_sent + RANDOM_ITEMS / 3;
         while (bytes_sent < stop_at) begin
            req_gaps      = ($urandom_range(0, 3) != 0);
            rsp_stalls_on = ($urandom_range(0, 3) != 0);
            lim = limit_now();
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 85)
               len = 16'($urandom_range(0, (lim < 12) ? lim : 12));
            else
               len = 16'($urandom_range(0, lim));
            if (r < 8)
               send_byte(8'($urandom_range(0, 255)));
            else if (r < 18)
               send_frame(16'($urandom_range(0, 65535)), len, 1'b1, -1);
            else if (r < 26) begin
               if (r[0])
                  len = 16'(lim + 1 + $urandom_range(0, 3));
               else
                  len = {8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};
               send_frame(16'($urandom_range(0, 65535)), len, 1'b0, -1);
            end else
               send_frame(16'($urandom_range(0, 65535)), len, 1'b0, -1);
         end
      end
      req_gaps = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // receiver holds off long enough for both buffer banks to fill
   task automatic test_backpressure();
      wait_idle();
      req_gaps = 1'b0;
      rsp_stalls_on = 1'b0;
      hold_off_cycles = 300;
      hold_off_req = 1'b1;
      repeat (3) send_frame(16'($urandom_range(0, 65535)), 16'd8, 1'b0, -1);
      req_gaps = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   initial begin : rsp_ready_gen
      int stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_left = hold_off_cycles;
         end else if (stall_left == 0 && rsp_stalls_on && $urandom_range(0, 4) == 0)
            stall_left = pick_gap();
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else
            rsp_if.ready <= 1'b1;
      end
   end

   function automatic void check_field(string field, logic [15:0] expv, logic [15:0] actv);
      if (actv !== expv) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, expv, actv);
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      deframed_type exp_res;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: unexpected transaction, expected none, got func 0x%0h idx %0d",
                        $time, rsp_if.function_code, rsp_if.byte_index);
         end else begin
            exp_res = pending_results.pop_front();
            results_checked++;
            check_field("function_code", exp_res.func, rsp_if.function_code);
            check_field("payload_length", 16'(exp_res.len), 16'(rsp_if.payload_length));
            check_field("has_payload", 16'(exp_res.has_payload), 16'(rsp_if.has_payload));
            check_field("byte_index", 16'(exp_res.idx), 16'(rsp_if.byte_index));
            check_field("payload_byte", 16'(exp_res.data), 16'(rsp_if.payload_byte));
            check_field("last", 16'(exp_res.last), 16'(rsp_if.last));
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.rx_byte <= '0;
      csr_we         <= 1'b0;
      csr_index      <= CSR_START_BYTE;
      csr_wdata      <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_length_limits();
      test_random();
      test_backpressure();
      wait_idle();

      $display("Covered %0d bytes: %0d frames verified, %0d dropped, %0d results checked,",
               bytes_sent, frames_verified, frames_dropped, results_checked);
      $display("with %0d cycles of input stall under receiver hold-off and random gaps.",
               input_stall_cycles);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
